### rtl/lge_pkg.sv
// Shared types and constants for the life grid generation engine.
`timescale 1ns / 1ps
package lge_pkg;

  localparam int DIM_W = 11;
  localparam int CRD_W = 10;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_EVOLVE = 2'd2;

  localparam logic [1:0] CELL_DEAD      = 2'd0;
  localparam logic [1:0] CELL_ALIVE     = 2'd1;
  localparam logic [1:0] CELL_NONVIABLE = 2'd2;

  localparam logic [1:0] CFG_ROWS    = 2'd0;
  localparam logic [1:0] CFG_COLUMNS = 2'd1;
  localparam logic [1:0] CFG_WRAP    = 2'd2;

  localparam logic [3:0] NBR_LAST = 4'd8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_COPY_END,
    ST_EVOLVE
  } state_t;

  typedef struct packed {
    logic             ok;
    logic [CRD_W-1:0] row;
    logic [CRD_W-1:0] col;
  } nbr_t;

endpackage

### rtl/lge_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module lge_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/lge_nbr_gen.sv
// Neighbor coordinate generator with edge wrap or edge masking.
`timescale 1ns / 1ps
module lge_nbr_gen (
  input  logic [lge_pkg::CRD_W-1:0] row,
  input  logic [lge_pkg::CRD_W-1:0] col,
  input  logic [lge_pkg::DIM_W-1:0] nr,
  input  logic [lge_pkg::DIM_W-1:0] nc,
  input  logic                      wrap,
  input  logic [2:0]                sel,
  output lge_pkg::nbr_t             nbr
);
  import lge_pkg::*;

  logic [CRD_W-1:0] up, down, left, right;
  logic             up_ok, down_ok, left_ok, right_ok;
  logic [DIM_W-1:0] row_p1, col_p1;

  always_comb begin
    row_p1   = DIM_W'(row) + DIM_W'(1);
    col_p1   = DIM_W'(col) + DIM_W'(1);
    up       = (row == '0) ? CRD_W'(nr - DIM_W'(1)) : row - CRD_W'(1);
    down     = (row_p1 == nr) ? '0 : CRD_W'(row_p1);
    left     = (col == '0) ? CRD_W'(nc - DIM_W'(1)) : col - CRD_W'(1);
    right    = (col_p1 == nc) ? '0 : CRD_W'(col_p1);
    up_ok    = wrap || (row != '0);
    down_ok  = wrap || (row_p1 < nr);
    left_ok  = wrap || (col != '0);
    right_ok = wrap || (col_p1 < nc);
    unique case (sel)
      3'd0:    nbr = '{ok: up_ok && left_ok,    row: up,   col: left};
      3'd1:    nbr = '{ok: up_ok,               row: up,   col: col};
      3'd2:    nbr = '{ok: up_ok && right_ok,   row: up,   col: right};
      3'd3:    nbr = '{ok: left_ok,             row: row,  col: left};
      3'd4:    nbr = '{ok: right_ok,            row: row,  col: right};
      3'd5:    nbr = '{ok: down_ok && left_ok,  row: down, col: left};
      3'd6:    nbr = '{ok: down_ok,             row: down, col: col};
      default: nbr = '{ok: down_ok && right_ok, row: down, col: right};
    endcase
  end

endmodule

### rtl/life_grid_generation_engine.sv
// Top level of the life grid generation engine: control sequencer and grid memories.
// After reset a clearing pass writes every one of the 2**(clog2(MAX_ROWS)+clog2(MAX_COLUMNS)) grid
// entries (4096 at defaults) before the first input transfer; configuration resets to 64, 64, 1.
// A write is answered straight from the idle state, a read through the registered grid memory port.
// An evolve first copies the grid's alive bits into a snapshot, then updates the cells from it, a pace
// set by the single snapshot read port that fetches the eight neighbors one per cycle.
// One item is in flight at a time; a new item is taken once the previous result is transferred.
`timescale 1ns / 1ps
module life_grid_generation_engine #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [15:0] in_tdata,   // row[5:0], column[11:6], cell_value[13:12], zero fill
  input  logic [1:0] in_tuser,    // kind[1:0]
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // read_value[1:0], done_res[2], zero fill
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);
  import lge_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;

  state_t state_r, state_nxt;
  logic [6:0] row_count_r, col_count_r;
  logic       wrap_r;
  logic [AW-1:0] clr_r;
  logic [CRD_W-1:0] cr_r, cc_r;
  logic [3:0] k_r;
  logic [3:0] sum_r;
  logic       nb_ok_r;
  logic [1:0] cell_r;
  logic       cp_v_r;
  logic [AW-1:0] cp_addr_r;
  logic       out_valid_r;
  logic [1:0] out_read_r;
  logic       out_done_r;

  logic [DIM_W-1:0] nr, nc;
  logic [5:0] in_row, in_col;
  logic [1:0] in_kind, in_val;
  logic       in_fire, in_range, grid_empty, last_cell;
  logic [AW-1:0] in_addr, cur_addr;
  logic       grid_we;
  logic [AW-1:0] grid_waddr, grid_raddr;
  logic [1:0] grid_wdata, grid_rdata;
  logic       snap_we, snap_rdata;
  logic [AW-1:0] snap_raddr;
  logic [3:0] total;
  logic [1:0] new_cell;
  logic       res_fire;
  logic [1:0] res_read;
  logic       res_done;
  nbr_t       nbr;

  assign nr = (DIM_W'(row_count_r) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : DIM_W'(row_count_r);
  assign nc = (DIM_W'(col_count_r) > DIM_W'(MAX_COLUMNS)) ?
              DIM_W'(MAX_COLUMNS) : DIM_W'(col_count_r);
  assign in_kind    = in_tuser;
  assign in_row     = in_tdata[5:0];
  assign in_col     = in_tdata[11:6];
  assign in_val     = in_tdata[13:12];
  assign in_tready  = (state_r == ST_IDLE) && !out_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign in_range   = (DIM_W'(in_row) < nr) && (DIM_W'(in_col) < nc);
  assign grid_empty = (nr == '0) || (nc == '0);
  assign in_addr    = {RW'(in_row), CW'(in_col)};
  assign cur_addr   = {RW'(cr_r), CW'(cc_r)};
  assign last_cell  = (DIM_W'(cr_r) + DIM_W'(1) == nr) && (DIM_W'(cc_r) + DIM_W'(1) == nc);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_done_r, out_read_r};

  lge_nbr_gen u_nbr (
    .row  (cr_r),
    .col  (cc_r),
    .nr   (nr),
    .nc   (nc),
    .wrap (wrap_r),
    .sel  (k_r[2:0]),
    .nbr  (nbr)
  );

  lge_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  lge_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_snap (
    .clk   (clk),
    .we    (snap_we),
    .waddr (cp_addr_r),
    .wdata (grid_rdata == CELL_ALIVE),
    .raddr (snap_raddr),
    .rdata (snap_rdata)
  );

  assign snap_we    = cp_v_r;
  assign snap_raddr = {RW'(nbr.row), CW'(nbr.col)};
  assign total      = sum_r + {3'd0, nb_ok_r && snap_rdata};

  always_comb begin
    if (cell_r == CELL_ALIVE) begin
      new_cell = ((total == 4'd2) || (total == 4'd3)) ? CELL_ALIVE : CELL_DEAD;
    end else begin
      new_cell = (total == 4'd3) ? CELL_ALIVE : CELL_DEAD;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_kind == KIND_READ && in_range) begin
            state_nxt = ST_READ;
          end else if (in_kind == KIND_EVOLVE && !grid_empty) begin
            state_nxt = ST_COPY;
          end
        end
      end
      ST_READ:     state_nxt = ST_IDLE;
      ST_COPY: begin
        if (last_cell) state_nxt = ST_COPY_END;
      end
      ST_COPY_END: state_nxt = ST_EVOLVE;
      ST_EVOLVE: begin
        if (k_r == NBR_LAST && last_cell) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    grid_we    = 1'b0;
    grid_waddr = cur_addr;
    grid_wdata = new_cell;
    grid_raddr = cur_addr;
    res_fire   = 1'b0;
    res_read   = CELL_DEAD;
    res_done   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        grid_we    = 1'b1;
        grid_waddr = clr_r;
        grid_wdata = CELL_DEAD;
      end
      ST_IDLE: begin
        grid_raddr = in_addr;
        grid_waddr = in_addr;
        grid_wdata = in_val;
        if (in_fire) begin
          unique case (in_kind)
            KIND_WRITE: begin
              grid_we  = in_range && (in_val != 2'd3);
              res_fire = 1'b1;
              res_done = in_range && (in_val != 2'd3);
            end
            KIND_READ: begin
              res_fire = !in_range;
            end
            KIND_EVOLVE: begin
              res_fire = grid_empty;
              res_done = 1'b1;
            end
            default: begin
              res_fire = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_fire = 1'b1;
        res_read = grid_rdata;
        res_done = 1'b1;
      end
      ST_EVOLVE: begin
        if (k_r == NBR_LAST) begin
          grid_we  = (cell_r != CELL_NONVIABLE);
          res_fire = last_cell;
          res_done = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      row_count_r <= 7'd64;
      col_count_r <= 7'd64;
      wrap_r      <= 1'b1;
      clr_r       <= '0;
      cr_r        <= '0;
      cc_r        <= '0;
      k_r         <= '0;
      sum_r       <= '0;
      nb_ok_r     <= 1'b0;
      cp_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ROWS:    row_count_r <= cfg_data;
          CFG_COLUMNS: col_count_r <= cfg_data;
          CFG_WRAP:    wrap_r      <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (state_r == ST_CLEAR) clr_r <= clr_r + AW'(1);
      cp_v_r <= (state_r == ST_COPY);
      if (in_fire) begin
        cr_r <= '0;
        cc_r <= '0;
        k_r  <= '0;
        sum_r <= '0;
      end else if (state_r == ST_COPY_END) begin
        cr_r <= '0;
        cc_r <= '0;
        k_r  <= '0;
        sum_r <= '0;
      end else if (state_r == ST_COPY ||
                   (state_r == ST_EVOLVE && k_r == NBR_LAST)) begin
        if (DIM_W'(cc_r) + DIM_W'(1) == nc) begin
          cc_r <= '0;
          cr_r <= cr_r + CRD_W'(1);
        end else begin
          cc_r <= cc_r + CRD_W'(1);
        end
        k_r   <= '0;
        sum_r <= '0;
      end else if (state_r == ST_EVOLVE) begin
        k_r <= k_r + 4'd1;
        if (k_r != '0) sum_r <= total;
      end
      nb_ok_r <= (state_r == ST_EVOLVE) && (k_r != NBR_LAST) && nbr.ok;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end else if (res_fire) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r <= cur_addr;
    if (state_r == ST_EVOLVE && k_r == 4'd1) cell_r <= grid_rdata;
    if (res_fire) begin
      out_read_r <= res_read;
      out_done_r <= res_done;
    end
  end

  a_no_grid_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> !grid_we) else $error("grid written during read");
  a_ready_needs_free_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_valid_r) else $error("input taken while result pending");
  a_nbr_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EVOLVE |-> k_r <= NBR_LAST) else $error("neighbor step out of range");
  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> out_valid_r) else $error("read produced no result");
  a_snap_only_after_copy: assert property (@(posedge clk) disable iff (!rst_n)
    snap_we |-> $past(state_r) == ST_COPY) else $error("snapshot write outside copy");

endmodule

### tb/life_grid_generation_engine_test.sv
// Self-checking testbench for the life grid generation engine, with a built-in grid predictor.
`timescale 1ns / 1ps
module life_grid_generation_engine_test;
  import lge_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] CELL_BAD = 2'd3;
  localparam int GRID = 64;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] row;
    logic [5:0] col;
    logic [1:0] value;
  } cell_op_t;

  typedef struct packed {
    logic [1:0] read_value;
    logic       done;
  } op_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  life_grid_generation_engine dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [1:0] grid_cells [GRID][GRID];
  logic       alive_snap [GRID][GRID];
  logic [6:0] rows_reg = 7'd64;
  logic [6:0] cols_reg = 7'd64;
  logic       wrap_reg = 1'b1;

  cell_op_t   pending_ops [$];
  op_result_t expected_results [$];
  cell_op_t   cur_op;
  bit         op_taken = 1'b1;
  int         tx_gap = 0;
  int         rx_stall = 0;
  bit         tx_burst = 1'b0;
  bit         rx_burst = 1'b0;
  bit         rx_hold = 1'b0;
  bit         hold_request = 1'b0;
  int         fail_count = 0;

  function automatic int used_rows();
    return rows_reg > GRID ? GRID : int'(rows_reg);
  endfunction

  function automatic int used_cols();
    return cols_reg > GRID ? GRID : int'(cols_reg);
  endfunction

  function automatic int live_neighbors(int r, int c, int nr, int nc);
    int total;
    int rr;
    int cc;
    total = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr != 0 || dc != 0) begin
          rr = r + dr;
          cc = c + dc;
          if (wrap_reg) begin
            rr = (rr + nr) % nr;
            cc = (cc + nc) % nc;
            total += alive_snap[rr][cc];
          end else if (rr >= 0 && rr < nr && cc >= 0 && cc < nc) begin
            total += alive_snap[rr][cc];
          end
        end
      end
    end
    return total;
  endfunction

  function automatic void step_generation();
    int nr;
    int nc;
    int n;
    nr = used_rows();
    nc = used_cols();
    if (nr == 0 || nc == 0) return;
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        alive_snap[r][c] = (grid_cells[r][c] == CELL_ALIVE);
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        if (grid_cells[r][c] != CELL_NONVIABLE) begin
          n = live_neighbors(r, c, nr, nc);
          if (grid_cells[r][c] == CELL_ALIVE) begin
            if (n != 2 && n != 3) grid_cells[r][c] = CELL_DEAD;
          end else if (n == 3) begin
            grid_cells[r][c] = CELL_ALIVE;
          end
        end
      end
    end
  endfunction

  function automatic op_result_t apply_op(cell_op_t op);
    op_result_t res;
    bit in_grid;
    res = '0;
    in_grid = op.row < used_rows() && op.col < used_cols();
    case (op.kind)
      KIND_WRITE: begin
        if (in_grid && op.value != CELL_BAD) begin
          grid_cells[op.row][op.col] = op.value;
          res.done = 1'b1;
        end
      end
      KIND_READ: begin
        if (in_grid) begin
          res.read_value = grid_cells[op.row][op.col];
          res.done = 1'b1;
        end
      end
      KIND_EVOLVE: begin
        step_generation();
        res.done = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Input side: transfers are recorded at the rising edge, the bus is driven at the falling edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_results.push_back(apply_op(cur_op));
      op_taken = 1'b1;
      if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
      tx_gap = tx_burst ? 0 : $urandom_range(0, 7);
    end
  end

  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !op_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        cur_op = pending_ops.pop_front();
        op_taken = 1'b0;
        in_tdata <= {2'b00, cur_op.value, cur_op.col, cur_op.row};
        in_tuser <= cur_op.kind;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side.
  always @(posedge clk) begin
    op_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: out_tdata=%h", out_tdata);
        fail_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_tdata[1:0] !== exp_res.read_value) begin
          $error("read_value expected %0d actual %0d", exp_res.read_value, out_tdata[1:0]);
          fail_count++;
        end
        if (out_tdata[2] !== exp_res.done) begin
          $error("done_res expected %0d actual %0d", exp_res.done, out_tdata[2]);
          fail_count++;
        end
      end
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      rx_stall = rx_burst ? 0 : $urandom_range(0, 7);
    end
  end

  always @(negedge clk) begin
    if (rx_hold || rx_stall > 0) begin
      out_tready <= 1'b0;
      if (!rx_hold) rx_stall--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    wait (hold_request);
    rx_hold = 1'b1;
    repeat (600) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic cell_op_t mk(logic [1:0] kind, int r, int c, logic [1:0] v);
    cell_op_t op;
    op.kind = kind;
    op.row = r[5:0];
    op.col = c[5:0];
    op.value = v;
    return op;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [6:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ROWS:    rows_reg = value;
      CFG_COLUMNS: cols_reg = value;
      default:     wrap_reg = value[0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(int nr, int nc, bit wrap);
    write_reg(CFG_ROWS, nr[6:0]);
    write_reg(CFG_COLUMNS, nc[6:0]);
    write_reg(CFG_WRAP, {6'd0, wrap});
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_ops.size() > 0 || in_tvalid || expected_results.size() > 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_random_ops(int count);
    int nr;
    int nc;
    int pick;
    nr = used_rows();
    nc = used_cols();
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (nr == 0 || nc == 0 || pick >= 87)
        pending_ops.push_back(mk(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                                 $urandom_range(0, 63), 2'($urandom_range(0, 3))));
      else if (pick < 45)
        pending_ops.push_back(mk(KIND_WRITE, $urandom_range(0, nr - 1),
                                 $urandom_range(0, nc - 1),
                                 $urandom_range(0, 9) < 7 ? CELL_ALIVE :
                                 ($urandom_range(0, 1) ? CELL_DEAD : CELL_NONVIABLE)));
      else if (pick < 75)
        pending_ops.push_back(mk(KIND_READ, $urandom_range(0, nr - 1),
                                 $urandom_range(0, nc - 1), 2'($urandom_range(0, 3))));
      else
        pending_ops.push_back(mk(KIND_EVOLVE, 0, 0, CELL_DEAD));
    end
  endtask

  initial begin
    int nr;
    int nc;
    foreach (grid_cells[r, c]) grid_cells[r][c] = CELL_DEAD;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Full-size grid: corner cells, alive and nonviable writes, invalid value and unused kind.
    pending_ops.push_back(mk(KIND_WRITE, 0, 0, CELL_ALIVE));
    pending_ops.push_back(mk(KIND_WRITE, 63, 63, CELL_NONVIABLE));
    pending_ops.push_back(mk(KIND_WRITE, 63, 0, CELL_BAD));
    pending_ops.push_back(mk(KIND_UNUSED, 63, 63, CELL_BAD));
    pending_ops.push_back(mk(KIND_READ, 0, 0, CELL_DEAD));
    pending_ops.push_back(mk(KIND_READ, 63, 63, CELL_DEAD));
    pending_ops.push_back(mk(KIND_READ, 63, 0, CELL_DEAD));
    pending_ops.push_back(mk(KIND_EVOLVE, 0, 0, CELL_DEAD));
    pending_ops.push_back(mk(KIND_READ, 0, 0, CELL_DEAD));
    drain();

    // Bounded 5x6 grid with a blinker touching the edge and out-of-range accesses.
    set_grid(5, 6, 1'b0);
    for (int c = 0; c < 3; c++) pending_ops.push_back(mk(KIND_WRITE, 0, c, CELL_ALIVE));
    pending_ops.push_back(mk(KIND_WRITE, 1, 1, CELL_NONVIABLE));
    pending_ops.push_back(mk(KIND_WRITE, 5, 2, CELL_ALIVE));
    pending_ops.push_back(mk(KIND_READ, 2, 6, CELL_DEAD));
    pending_ops.push_back(mk(KIND_EVOLVE, 0, 0, CELL_DEAD));
    pending_ops.push_back(mk(KIND_READ, 0, 1, CELL_DEAD));
    pending_ops.push_back(mk(KIND_READ, 4, 1, CELL_DEAD));
    drain();

    // The same 5x6 grid with toroidal wrap, then a tiny wrapped grid.
    write_reg(CFG_WRAP, 7'd1);
    pending_ops.push_back(mk(KIND_EVOLVE, 0, 0, CELL_DEAD));
    pending_ops.push_back(mk(KIND_READ, 4, 1, CELL_DEAD));
    drain();
    set_grid(1, 2, 1'b1);
    pending_ops.push_back(mk(KIND_WRITE, 0, 1, CELL_ALIVE));
    pending_ops.push_back(mk(KIND_EVOLVE, 0, 0, CELL_DEAD));
    pending_ops.push_back(mk(KIND_READ, 0, 0, CELL_DEAD));
    pending_ops.push_back(mk(KIND_READ, 0, 1, CELL_DEAD));
    drain();

    // An empty grid, then oversized counts that act as the full grid.
    set_grid(0, 64, 1'b1);
    pending_ops.push_back(mk(KIND_WRITE, 0, 0, CELL_ALIVE));
    pending_ops.push_back(mk(KIND_EVOLVE, 0, 0, CELL_DEAD));
    pending_ops.push_back(mk(KIND_READ, 0, 0, CELL_DEAD));
    drain();
    set_grid(100, 127, 1'b0);
    pending_ops.push_back(mk(KIND_WRITE, 62, 63, CELL_ALIVE));
    pending_ops.push_back(mk(KIND_WRITE, 63, 62, CELL_ALIVE));
    pending_ops.push_back(mk(KIND_EVOLVE, 0, 0, CELL_DEAD));
    pending_ops.push_back(mk(KIND_READ, 63, 63, CELL_DEAD));
    drain();

    add_random_ops(12);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      nr = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 8);
      nc = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 8);
      set_grid(nr, nc, 1'($urandom_range(0, 1)));
      add_random_ops(18);
      if (phase == 2) hold_request = 1'b1;
      drain();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

### sim.f
rtl/lge_pkg.sv
rtl/lge_ram.sv
rtl/lge_nbr_gen.sv
rtl/life_grid_generation_engine.sv
tb/life_grid_generation_engine_test.sv
